// ===== rtl/ibc_pkg.sv =====
// ibc_pkg: shared constants, phase codes and the lane control struct of the
// imu bias calibration block
// no dependencies
package ibc_pkg;

    localparam int SAMPLES = 200;
    localparam int DATA_W  = 16;
    localparam int ONE_G_W = 15;
    localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd8196;

    // sample counter holds 0 .. SAMPLES-1 between items
    localparam int CNT_W = $clog2(SAMPLES + 1);

    // accel z minus one g spans 17 bits signed, a group sum grows by log2(SAMPLES)
    localparam int SUM_W = DATA_W + 1 + $clog2(SAMPLES);
    localparam int MAG_W = SUM_W;

    // floor(2^MAG_W / SAMPLES): quotient estimate is exact or one low
    localparam longint unsigned RECIP = (64'd1 << MAG_W) / SAMPLES;
    localparam logic [MAG_W:0]   RECIP_M = (MAG_W + 1)'(RECIP);
    localparam logic [MAG_W-1:0] DIV_D   = MAG_W'(SAMPLES);

    localparam logic [1:0] PH_GYRO  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_IDLE  = 2'd2;

    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 2;
    localparam logic [ADDR_W-1:0] REG_ONE_G_ADDR = 2'd0;

    localparam int NUM_AXES = 3;

    typedef struct packed {
        logic       acc;         // word accepted this cycle
        logic       gyro_sel;    // lane sums gyro samples (else accel)
        logic       zero_gyro;   // gyro group starts: offsets read as zero now
        logic       zero_accel;  // accel group starts: offsets read as zero now
        logic       drop_accel;  // clear accel offsets after this word
        logic       accum;       // add this word to the running sum
        logic       clr_sum;     // group complete: sum back to zero
        logic       launch;      // start the offset divider on the final sum
        logic       launch_gyro; // divider result goes to gyro offsets
    } ibc_ctl_t;

endpackage

// ===== rtl/ibc_in_if.sv =====
// ibc_in_if: sample channel, valid/ready plus raw sensor words and requests
// depends on ibc_pkg
interface ibc_in_if import ibc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] raw_acc_x;
    logic signed [DATA_W-1:0] raw_acc_y;
    logic signed [DATA_W-1:0] raw_acc_z;
    logic signed [DATA_W-1:0] raw_gyro_x;
    logic signed [DATA_W-1:0] raw_gyro_y;
    logic signed [DATA_W-1:0] raw_gyro_z;
    logic                     request_gyro_cal;
    logic                     request_accel_cal;

    modport source (
        output valid, raw_acc_x, raw_acc_y, raw_acc_z,
               raw_gyro_x, raw_gyro_y, raw_gyro_z,
               request_gyro_cal, request_accel_cal,
        input  ready
    );

    modport sink (
        input  valid, raw_acc_x, raw_acc_y, raw_acc_z,
               raw_gyro_x, raw_gyro_y, raw_gyro_z,
               request_gyro_cal, request_accel_cal,
        output ready
    );
endinterface

// ===== rtl/ibc_out_if.sv =====
// ibc_out_if: result channel, valid/ready plus corrected words and status
// depends on ibc_pkg
interface ibc_out_if import ibc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] acc_x_out;
    logic signed [DATA_W-1:0] acc_y_out;
    logic signed [DATA_W-1:0] acc_z_out;
    logic signed [DATA_W-1:0] gyro_x_out;
    logic signed [DATA_W-1:0] gyro_y_out;
    logic signed [DATA_W-1:0] gyro_z_out;
    logic [1:0]               cal_phase;
    logic                     cal_finished;

    modport source (
        output valid, acc_x_out, acc_y_out, acc_z_out,
               gyro_x_out, gyro_y_out, gyro_z_out, cal_phase, cal_finished,
        input  ready
    );

    modport sink (
        input  valid, acc_x_out, acc_y_out, acc_z_out,
               gyro_x_out, gyro_y_out, gyro_z_out, cal_phase, cal_finished,
        output ready
    );
endinterface

// ===== rtl/ibc_lane.sv =====
// ibc_lane: one axis: offset subtraction, group accumulator and a two-stage
// reciprocal divider that turns the final sum into the new offset
// depends on ibc_pkg
module ibc_lane import ibc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ibc_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] raw_acc,
    input  logic signed [DATA_W-1:0] raw_gyro,
    input  logic [ONE_G_W-1:0]       acc_bias,
    output logic signed [DATA_W-1:0] acc_out,
    output logic signed [DATA_W-1:0] gyro_out
);

    logic [DATA_W-1:0]       gyro_off_reg;
    logic [DATA_W-1:0]       accel_off_reg;
    logic signed [SUM_W-1:0] sum_reg;

    // divider stage 1: magnitude of final sum
    logic                    d1_valid_reg;
    logic [MAG_W-1:0]        d1_mag_reg;
    logic                    d1_neg_reg;
    logic                    d1_gyro_reg;
    // divider stage 2: quotient estimate
    logic                    d2_valid_reg;
    logic [MAG_W-1:0]        d2_mag_reg;
    logic [MAG_W-1:0]        d2_q_reg;
    logic                    d2_neg_reg;
    logic                    d2_gyro_reg;

    logic [DATA_W-1:0]       gyro_off_eff;
    logic [DATA_W-1:0]       accel_off_eff;
    logic signed [SUM_W-1:0] acc_ext;
    logic signed [SUM_W-1:0] gyro_ext;
    logic signed [SUM_W-1:0] bias_ext;
    logic signed [SUM_W-1:0] sample_v;
    logic signed [SUM_W-1:0] sum_new;
    logic signed [SUM_W-1:0] sum_neg;
    logic [MAG_W-1:0]        mag_new;
    logic [2*MAG_W:0]        prod;
    logic [2*MAG_W-1:0]      qd;
    logic [MAG_W-1:0]        rem;
    logic [MAG_W-1:0]        q_fix;
    logic [MAG_W-1:0]        q_signed;

    always_comb
    begin
        gyro_off_eff  = ctl.zero_gyro  ? '0 : gyro_off_reg;
        accel_off_eff = ctl.zero_accel ? '0 : accel_off_reg;
        acc_out  = DATA_W'(raw_acc - accel_off_eff);
        gyro_out = DATA_W'(raw_gyro - gyro_off_eff);

        acc_ext  = SUM_W'(raw_acc);
        gyro_ext = SUM_W'(raw_gyro);
        bias_ext = $signed(SUM_W'(acc_bias));
        sample_v = ctl.gyro_sel ? gyro_ext : SUM_W'(acc_ext - bias_ext);
        sum_new  = SUM_W'(sum_reg + sample_v);
        sum_neg  = SUM_W'(-sum_new);
        mag_new  = sum_new[SUM_W-1] ? MAG_W'($unsigned(sum_neg))
                                    : MAG_W'($unsigned(sum_new));

        prod = (2*MAG_W + 1)'(d1_mag_reg) * (2*MAG_W + 1)'(RECIP_M);

        // estimate is the quotient or one below it
        qd       = (2*MAG_W)'(d2_q_reg) * (2*MAG_W)'(DIV_D);
        rem      = MAG_W'(d2_mag_reg - qd[MAG_W-1:0]);
        q_fix    = (rem >= DIV_D) ? MAG_W'(d2_q_reg + 1'b1) : d2_q_reg;
        q_signed = d2_neg_reg ? MAG_W'(~q_fix + 1'b1) : q_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            gyro_off_reg  <= '0;
            accel_off_reg <= '0;
            d1_valid_reg  <= 1'b0;
            d2_valid_reg  <= 1'b0;
        end
        else
        begin
            d1_valid_reg <= ctl.launch;
            d2_valid_reg <= d1_valid_reg;

            if (ctl.clr_sum)
            begin
                sum_reg <= '0;
            end
            else if (ctl.accum)
            begin
                sum_reg <= sum_new;
            end

            if (ctl.acc && ctl.zero_gyro)
            begin
                gyro_off_reg <= '0;
            end
            if (ctl.acc && (ctl.zero_accel || ctl.drop_accel))
            begin
                accel_off_reg <= '0;
            end

            if (d2_valid_reg)
            begin
                if (d2_gyro_reg)
                begin
                    gyro_off_reg <= q_signed[DATA_W-1:0];
                end
                else
                begin
                    accel_off_reg <= q_signed[DATA_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.launch)
        begin
            d1_mag_reg  <= mag_new;
            d1_neg_reg  <= sum_new[SUM_W-1];
            d1_gyro_reg <= ctl.launch_gyro;
        end
        d2_mag_reg  <= d1_mag_reg;
        d2_q_reg    <= prod[2*MAG_W-1:MAG_W];
        d2_neg_reg  <= d1_neg_reg;
        d2_gyro_reg <= d1_gyro_reg;
    end

endmodule

// ===== rtl/ibc_ctl.sv =====
// ibc_ctl: calibration sequencer: phase, sample count, pending accel request,
// input handshake and the stall while the lanes divide
// depends on ibc_pkg
module ibc_ctl import ibc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       req_gyro,
    input  logic       req_accel,
    input  logic       out_free,
    output logic       in_ready,
    output ibc_ctl_t   ctl,
    output logic [1:0] ph_now,
    output logic       done
);

    logic [1:0]       phase_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pending_reg;
    logic [1:0]       busy_reg;

    logic             in_acc;
    logic             idle;
    logic             start_g;
    logic             start_a;
    logic             pend_set;
    logic             pend_eff;
    logic             restart;
    logic             active;
    logic [CNT_W-1:0] cnt_new;

    always_comb
    begin
        in_ready = (busy_reg == 2'b00) && out_free;
        in_acc   = in_valid && in_ready;
        idle     = (phase_reg == PH_IDLE);
        start_g  = idle && req_gyro;
        start_a  = idle && !req_gyro && req_accel;
        ph_now   = start_g ? PH_GYRO : (start_a ? PH_ACCEL : phase_reg);
        active   = (ph_now != PH_IDLE);
        pend_set = (phase_reg == PH_ACCEL) && req_accel;
        pend_eff = pending_reg || pend_set;
        cnt_new  = CNT_W'(count_reg + 1'b1);
        done     = active && (cnt_new == CNT_W'(SAMPLES));
        restart  = done && (ph_now == PH_ACCEL) && pend_eff;

        ctl.acc         = in_acc;
        ctl.gyro_sel    = (ph_now == PH_GYRO);
        ctl.zero_gyro   = start_g;
        ctl.zero_accel  = start_a;
        ctl.drop_accel  = done && ((ph_now == PH_GYRO) || restart);
        ctl.accum       = in_acc && active && !done;
        ctl.clr_sum     = in_acc && done;
        // a restarted accel group throws its average away
        ctl.launch      = in_acc && done && !restart;
        ctl.launch_gyro = (ph_now == PH_GYRO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_GYRO;
            count_reg   <= '0;
            pending_reg <= 1'b0;
            busy_reg    <= 2'b00;
        end
        else
        begin
            busy_reg <= {busy_reg[0], ctl.launch};
            if (in_acc)
            begin
                if (done)
                begin
                    count_reg <= '0;
                    phase_reg <= ((ph_now == PH_GYRO) || restart) ? PH_ACCEL : PH_IDLE;
                end
                else if (active)
                begin
                    count_reg <= cnt_new;
                    phase_reg <= ph_now;
                end

                if (done && (ph_now == PH_ACCEL))
                begin
                    pending_reg <= 1'b0;
                end
                else if (pend_set)
                begin
                    pending_reg <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // no word may pass before the new offsets land in the lanes
    a_stall_after_launch: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.launch |=> !in_ready ##1 !in_ready)
        else $error("word accepted while offsets were being divided");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (count_reg == '0))
        else $error("sample count left over in idle phase");

    a_pending_in_accel: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (phase_reg == PH_ACCEL))
        else $error("pending accel request outside accel phase");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && done |=> (count_reg == '0))
        else $error("sample count not cleared after group end");
`endif

endmodule

// ===== rtl/ibc_merge.sv =====
// ibc_merge: output register that gathers the three lane words and the
// sequencer status into one result word
// depends on ibc_pkg, ibc_out_if
module ibc_merge import ibc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic signed [DATA_W-1:0] acc_w  [NUM_AXES],
    input  logic signed [DATA_W-1:0] gyro_w [NUM_AXES],
    input  logic [1:0]               ph,
    input  logic                     done,
    output logic                     out_free,
    ibc_out_if.source                res
);

    logic                     valid_reg;
    logic signed [DATA_W-1:0] acc_reg  [NUM_AXES];
    logic signed [DATA_W-1:0] gyro_reg [NUM_AXES];
    logic [1:0]               ph_reg;
    logic                     done_reg;

    assign out_free         = !valid_reg || res.ready;
    assign res.valid        = valid_reg;
    assign res.acc_x_out    = acc_reg[0];
    assign res.acc_y_out    = acc_reg[1];
    assign res.acc_z_out    = acc_reg[2];
    assign res.gyro_x_out   = gyro_reg[0];
    assign res.gyro_y_out   = gyro_reg[1];
    assign res.gyro_z_out   = gyro_reg[2];
    assign res.cal_phase    = ph_reg;
    assign res.cal_finished = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg  <= acc_w;
            gyro_reg <= gyro_w;
            ph_reg   <= ph;
            done_reg <= done;
        end
    end

endmodule

// ===== rtl/imu_bias_calibration.sv =====
// imu_bias_calibration: accelerometer and gyroscope zero-offset removal with
// an averaging calibration sequence; top level with the configuration port
// depends on ibc_pkg, ibc_in_if, ibc_out_if, ibc_lane, ibc_ctl, ibc_merge
//
// One sample word is taken per clock and its corrected result appears on the
// result channel in the next cycle through an output register; a waiting result
// does not block the next word unless the result side stalls. Three axis lanes
// each subtract their offsets and accumulate the calibration sum, and the
// sequencer walks gyro averaging, accel averaging and idle. The word that ends
// a calibration group stalls the input: each lane then divides its sum
// by the sample count through a multiply by a constant reciprocal followed by a
// one-step correction, and no word is taken until the new offsets are in
// place. An accel group that restarts on a pending request drops its average
// and does not stall the input. No memory, no clearing pass after reset.
// accel_one_g sits at byte address 0 and is read back there.
module imu_bias_calibration import ibc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ibc_in_if.sink                smp,
    ibc_out_if.source             res
);

    logic [ONE_G_W-1:0]       one_g_reg;
    ibc_ctl_t                 ctl;
    logic [1:0]               ph_now;
    logic                     done;
    logic                     out_free;
    logic                     in_ready;
    logic signed [DATA_W-1:0] raw_acc  [NUM_AXES];
    logic signed [DATA_W-1:0] raw_gyro [NUM_AXES];
    logic signed [DATA_W-1:0] acc_w    [NUM_AXES];
    logic signed [DATA_W-1:0] gyro_w   [NUM_AXES];

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ONE_G_ADDR) ? APB_DATA_W'(one_g_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_g_reg <= ONE_G_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_ONE_G_ADDR))
        begin
            one_g_reg <= pwdata[ONE_G_W-1:0];
        end
    end

    assign raw_acc[0]  = smp.raw_acc_x;
    assign raw_acc[1]  = smp.raw_acc_y;
    assign raw_acc[2]  = smp.raw_acc_z;
    assign raw_gyro[0] = smp.raw_gyro_x;
    assign raw_gyro[1] = smp.raw_gyro_y;
    assign raw_gyro[2] = smp.raw_gyro_z;
    assign smp.ready   = in_ready;

    ibc_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smp.valid),
        .req_gyro  (smp.request_gyro_cal),
        .req_accel (smp.request_accel_cal),
        .out_free  (out_free),
        .in_ready  (in_ready),
        .ctl       (ctl),
        .ph_now    (ph_now),
        .done      (done)
    );

    // one g comes off the z axis only
    for (genvar i = 0; i < NUM_AXES; i++)
    begin : g_lane
        ibc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .raw_acc  (raw_acc[i]),
            .raw_gyro (raw_gyro[i]),
            .acc_bias ((i == NUM_AXES - 1) ? one_g_reg : '0),
            .acc_out  (acc_w[i]),
            .gyro_out (gyro_w[i])
        );
    end

    ibc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ctl.acc),
        .acc_w    (acc_w),
        .gyro_w   (gyro_w),
        .ph       (ph_now),
        .done     (done),
        .out_free (out_free),
        .res      (res)
    );

endmodule
